### rtl/rgbc_pkg.sv
// ----------------------------------------------------------------------------
// rgbc_pkg
// Shared types, constants and control structs of the RGBC lux / CCT block.
// ----------------------------------------------------------------------------
package rgbc_pkg;

   // serial divider sizes
   localparam int DIVIDEND_W = 36;
   localparam int DIVISOR_W  = 26;
   localparam int COUNT_W    = 6;

   // gain stepping thresholds on the raw clear count
   localparam logic [15:0] GAIN_UP_BELOW   = 16'd200;
   localparam logic [15:0] GAIN_DOWN_ABOVE = 16'd60000;
   localparam logic [1:0]  GAIN_MIN_CODE   = 2'd0;
   localparam logic [1:0]  GAIN_MAX_CODE   = 2'd3;
   localparam logic [1:0]  GAIN_RESET_CODE = 2'd1;

   localparam logic [25:0] LEVEL_MAX   = 26'd65535000;
   localparam logic [9:0]  LEVEL_SCALE = 10'd1000;

   typedef enum logic [2:0] {
      CSR_ITIME = 3'd0,
      CSR_CCT_COEF = 3'd1,
      CSR_CCT_OFFSET = 3'd2,
      CSR_RED_WEIGHT = 3'd3,
      CSR_GREEN_WEIGHT = 3'd4,
      CSR_BLUE_WEIGHT = 3'd5,
      CSR_GLASS = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      STAT_OK = 2'd0,
      STAT_READ_FAIL = 2'd1,
      STAT_CPL_ZERO = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      JOB_CPL, JOB_RED, JOB_GREEN, JOB_BLUE, JOB_CLEAR, JOB_LUX, JOB_CCT
   } job_type;

   typedef enum logic [1:0] {
      MAC_RED, MAC_GREEN, MAC_BLUE
   } mac_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CPL_START, S_CPL_WAIT, S_CHECK, S_MAC_RED, S_MAC_GREEN,
      S_MAC_BLUE, S_DIV_START, S_DIV_WAIT, S_FINISH
   } state_type;

   typedef struct packed {
      logic [15:0] raw_clear;
      logic [15:0] raw_red;
      logic [15:0] raw_green;
      logic [15:0] raw_blue;
      logic        read_ok;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [25:0] red_level;
      logic [25:0] green_level;
      logic [25:0] blue_level;
      logic [25:0] clear_level;
      logic [31:0] illuminance;
      logic [31:0] colour_temp;
      logic [1:0]  gain_code;
   } rsp_type;

   typedef struct packed {
      logic [19:0]        integration_time_us;
      logic [15:0]        cct_coefficient;
      logic signed [15:0] cct_offset;
      logic signed [15:0] red_lux_weight;
      logic signed [15:0] green_lux_weight;
      logic signed [15:0] blue_lux_weight;
      logic [15:0]        glass_device_factor;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic    load;
      logic    div_start;
      logic    prep;
      logic    mac_en;
      mac_type mac_sel;
      job_type job;
      logic    commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic read_ok;
      logic cpl_zero;
   } dp_stat_type;

endpackage

### rtl/rgbc_lux_cct_autogain.sv
// ----------------------------------------------------------------------------
// rgbc_lux_cct_autogain
// RGBC sample post-processing: IR removal, channel levels, lux, CCT, autogain.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one raw clear/red/green/blue sample per beat, taken when
//   req_valid is high and req_stall low. rsp_* returns one result beat per
//   sample, taken when rsp_valid is high and rsp_stall low. csr_* writes the
//   configuration registers (csr_ready is always high); write only while idle.
// Sequencing:
//   one sample at a time; a good sample reaches rsp_valid after seven runs
//   of the shared one-bit-per-cycle divider (counts-per-lux, four levels,
//   lux, colour temperature). A failed read skips all divisions, and a zero
//   counts-per-lux skips all but the first.
// Reset:
//   registers return to their defaults and the gain to 4x; no beat pending.
// Stall:
//   a finished result waits in the output register; the next sample is taken
//   and computed meanwhile, and its commit waits until the register frees.
// ----------------------------------------------------------------------------
module rgbc_lux_cct_autogain import rgbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_addr,
   input  logic [19:0] csr_wdata
);

   cfg_type     cfg_ff;
   rsp_type     rsp_data_ff;
   logic        rsp_valid_ff;
   logic        rsp_hold;
   cmd_type     cmd;
   dp_stat_type stat;
   rsp_type     result;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.integration_time_us <= 20'd2400;
         cfg_ff.cct_coefficient     <= '0;
         cfg_ff.cct_offset          <= '0;
         cfg_ff.red_lux_weight      <= '0;
         cfg_ff.green_lux_weight    <= '0;
         cfg_ff.blue_lux_weight     <= '0;
         cfg_ff.glass_device_factor <= 16'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_addr))
            CSR_ITIME:        cfg_ff.integration_time_us <= csr_wdata;
            CSR_CCT_COEF:     cfg_ff.cct_coefficient     <= csr_wdata[15:0];
            CSR_CCT_OFFSET:   cfg_ff.cct_offset          <= csr_wdata[15:0];
            CSR_RED_WEIGHT:   cfg_ff.red_lux_weight      <= csr_wdata[15:0];
            CSR_GREEN_WEIGHT: cfg_ff.green_lux_weight    <= csr_wdata[15:0];
            CSR_BLUE_WEIGHT:  cfg_ff.blue_lux_weight     <= csr_wdata[15:0];
            CSR_GLASS:        cfg_ff.glass_device_factor <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign rsp_hold = rsp_valid_ff && rsp_stall;

   rgbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_hold  (rsp_hold),
      .stat      (stat),
      .cmd       (cmd)
   );

   rgbc_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .result   (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) rsp_data_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/rgbc_div.sv
// ----------------------------------------------------------------------------
// rgbc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rgbc_div import rgbc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic                  done
);

   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVIDEND_W-1:0] quot_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // trial subtract of the shifted partial remainder
   assign shifted = {rem_ff, quot_ff[DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, divisor};
   assign fits    = shifted >= {1'b0, divisor};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= COUNT_W'(DIVIDEND_W);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == COUNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // remainder and quotient shift
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quot_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff  <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quot_ff <= {quot_ff[DIVIDEND_W-2:0], fits};
      end
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without run");
   a_count_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> count_ff != '0) else $error("divider busy with zero count");

endmodule

### rtl/rgbc_dp.sv
// ----------------------------------------------------------------------------
// rgbc_dp
// Datapath: sample and IR removal, weight MAC, shared divider, result fields.
// ----------------------------------------------------------------------------
module rgbc_dp import rgbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  req_type     req_data,
   input  cmd_type     cmd,
   output dp_stat_type stat,
   output rsp_type     result
);

   req_type            smp_ff;
   logic [25:0]        cpl_ff;
   logic signed [17:0] red_c_ff, green_c_ff, blue_c_ff;
   logic signed [35:0] acc_ff;
   logic signed [34:0] ctn_ff;
   logic [25:0]        red_lvl_ff, green_lvl_ff, blue_lvl_ff, clear_lvl_ff;
   logic [31:0]        lux_ff, ct_ff;
   logic [1:0]         gain_ff;

   logic signed [19:0] ir_sum, ir, red_c20, green_c20, blue_c20;
   logic signed [15:0] mac_w;
   logic signed [17:0] mac_v;
   logic signed [33:0] mac_prod;
   logic signed [34:0] ctn_prod;
   logic [25:0]        it_gain;
   logic [DIVIDEND_W-1:0] dividend, quot;
   logic [DIVISOR_W-1:0]  divisor;
   logic                  div_done;
   logic [DIVISOR_W-1:0]  red_mag;
   logic [35:0]           acc_mag;
   logic [25:0]           q_level;
   logic                  ct_neg;
   logic signed [37:0]    ct_val;
   logic [1:0]            gain_next;
   status_type            status;

   // integration time times the analog gain factor
   always_comb begin
      case (gain_ff)
         2'd0:    it_gain = {6'b0, cfg.integration_time_us};
         2'd1:    it_gain = {4'b0, cfg.integration_time_us, 2'b0};
         2'd2:    it_gain = {2'b0, cfg.integration_time_us, 4'b0};
         default: it_gain = {cfg.integration_time_us, 6'b0}
                          - {4'b0, cfg.integration_time_us, 2'b0};
      endcase
   end

   // ir removal, floor of half of r+g+b-c
   assign ir_sum    = $signed({4'b0, smp_ff.raw_red}) + $signed({4'b0, smp_ff.raw_green})
                    + $signed({4'b0, smp_ff.raw_blue}) - $signed({4'b0, smp_ff.raw_clear});
   assign ir        = ir_sum >>> 1;
   assign red_c20   = $signed({4'b0, smp_ff.raw_red}) - ir;
   assign green_c20 = $signed({4'b0, smp_ff.raw_green}) - ir;
   assign blue_c20  = $signed({4'b0, smp_ff.raw_blue}) - ir;

   // one weight product per cycle
   always_comb begin
      case (cmd.mac_sel)
         MAC_RED: begin
            mac_w = cfg.red_lux_weight;
            mac_v = red_c_ff;
         end
         MAC_GREEN: begin
            mac_w = cfg.green_lux_weight;
            mac_v = green_c_ff;
         end
         default: begin
            mac_w = cfg.blue_lux_weight;
            mac_v = blue_c_ff;
         end
      endcase
   end
   assign mac_prod = mac_w * mac_v;
   assign ctn_prod = $signed({1'b0, cfg.cct_coefficient}) * blue_c_ff;

   // divider operands per job
   assign red_mag = DIVISOR_W'(red_c_ff[17] ? 18'(-red_c_ff) : 18'(red_c_ff));
   assign acc_mag = acc_ff[35] ? 36'(-acc_ff) : 36'(acc_ff);

   always_comb begin
      case (cmd.job)
         JOB_CPL: begin
            dividend = DIVIDEND_W'(it_gain);
            divisor  = DIVISOR_W'(cfg.glass_device_factor);
         end
         JOB_RED: begin
            dividend = DIVIDEND_W'(27'(red_c_ff[16:0]) * 27'(LEVEL_SCALE));
            divisor  = cpl_ff;
         end
         JOB_GREEN: begin
            dividend = DIVIDEND_W'(27'(green_c_ff[16:0]) * 27'(LEVEL_SCALE));
            divisor  = cpl_ff;
         end
         JOB_BLUE: begin
            dividend = DIVIDEND_W'(27'(blue_c_ff[16:0]) * 27'(LEVEL_SCALE));
            divisor  = cpl_ff;
         end
         JOB_CLEAR: begin
            dividend = DIVIDEND_W'(27'(smp_ff.raw_clear) * 27'(LEVEL_SCALE));
            divisor  = cpl_ff;
         end
         JOB_LUX: begin
            dividend = acc_mag;
            divisor  = cpl_ff;
         end
         default: begin
            dividend = DIVIDEND_W'(ctn_ff[34] ? 35'(-ctn_ff) : 35'(ctn_ff));
            divisor  = red_mag;
         end
      endcase
   end

   rgbc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .quotient (quot),
      .done     (div_done)
   );

   // saturated level and signed colour temperature
   assign q_level = (quot > DIVIDEND_W'(LEVEL_MAX)) ? LEVEL_MAX : quot[25:0];
   assign ct_neg  = ctn_ff[34] ^ red_c_ff[17];
   assign ct_val  = (ct_neg ? -$signed({2'b0, quot}) : $signed({2'b0, quot}))
                  + 38'(cfg.cct_offset);

   // sample and working registers
   always_ff @(posedge clock) begin
      if (cmd.load) smp_ff <= req_data;
      if (cmd.prep) begin
         red_c_ff   <= red_c20[17:0];
         green_c_ff <= green_c20[17:0];
         blue_c_ff  <= blue_c20[17:0];
      end
      if (cmd.mac_en) begin
         if (cmd.mac_sel == MAC_RED) begin
            acc_ff <= 36'(mac_prod);
            ctn_ff <= ctn_prod;
         end else begin
            acc_ff <= acc_ff + 36'(mac_prod);
         end
      end
      if (div_done) begin
         case (cmd.job)
            // a zero glass factor gives zero counts-per-lux
            JOB_CPL:   cpl_ff       <= (cfg.glass_device_factor == '0) ? '0 : quot[25:0];
            JOB_RED:   red_lvl_ff   <= red_c_ff[17] ? '0 : q_level;
            JOB_GREEN: green_lvl_ff <= green_c_ff[17] ? '0 : q_level;
            JOB_BLUE:  blue_lvl_ff  <= blue_c_ff[17] ? '0 : q_level;
            JOB_CLEAR: clear_lvl_ff <= q_level;
            JOB_LUX: begin
               if (acc_ff[35])             lux_ff <= '0;
               else if (quot[35:32] != '0) lux_ff <= '1;
               else                        lux_ff <= quot[31:0];
            end
            default: begin
               if (red_c_ff == '0 || ct_val < 0) ct_ff <= '0;
               else if (ct_val[37:32] != '0)     ct_ff <= '1;
               else                              ct_ff <= ct_val[31:0];
            end
         endcase
      end
   end

   // gain step from the raw clear count
   always_comb begin
      gain_next = gain_ff;
      if (smp_ff.raw_clear < GAIN_UP_BELOW) begin
         if (gain_ff != GAIN_MAX_CODE) gain_next = gain_ff + 1'b1;
      end else if (smp_ff.raw_clear > GAIN_DOWN_ABOVE) begin
         if (gain_ff != GAIN_MIN_CODE) gain_next = gain_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET_CODE;
      end else if (cmd.commit && status == STAT_OK) begin
         gain_ff <= gain_next;
      end
   end

   // result beat
   always_comb begin
      if (!smp_ff.read_ok)   status = STAT_READ_FAIL;
      else if (cpl_ff == '0) status = STAT_CPL_ZERO;
      else                   status = STAT_OK;
      result        = '0;
      result.status = status;
      if (status == STAT_OK) begin
         result.red_level   = red_lvl_ff;
         result.green_level = green_lvl_ff;
         result.blue_level  = blue_lvl_ff;
         result.clear_level = clear_lvl_ff;
         result.illuminance = lux_ff;
         result.colour_temp = ct_ff;
         result.gain_code   = gain_next;
      end else begin
         result.gain_code   = gain_ff;
      end
   end

   assign stat.div_done = div_done;
   assign stat.read_ok  = smp_ff.read_ok;
   assign stat.cpl_zero = (cpl_ff == '0);

endmodule

### rtl/rgbc_ctrl.sv
// ----------------------------------------------------------------------------
// rgbc_ctrl
// Sequencer: input handshake, division jobs and result commit.
// ----------------------------------------------------------------------------
module rgbc_ctrl import rgbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        rsp_hold,
   input  dp_stat_type stat,
   output cmd_type     cmd
);

   state_type state_ff, state_in;
   job_type   job_ff, job_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         job_ff   <= JOB_CPL;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      cmd       = '0;
      cmd.job   = job_ff;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            job_in    = JOB_CPL;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CPL_START;
            end
         end
         S_CPL_START: begin
            if (!stat.read_ok) begin
               state_in = S_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_CPL_WAIT;
            end
         end
         S_CPL_WAIT: begin
            if (stat.div_done) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.cpl_zero) begin
               state_in = S_FINISH;
            end else begin
               cmd.prep = 1'b1;
               state_in = S_MAC_RED;
            end
         end
         S_MAC_RED: begin
            cmd.mac_en  = 1'b1;
            cmd.mac_sel = MAC_RED;
            state_in    = S_MAC_GREEN;
         end
         S_MAC_GREEN: begin
            cmd.mac_en  = 1'b1;
            cmd.mac_sel = MAC_GREEN;
            state_in    = S_MAC_BLUE;
         end
         S_MAC_BLUE: begin
            cmd.mac_en  = 1'b1;
            cmd.mac_sel = MAC_BLUE;
            job_in      = JOB_RED;
            state_in    = S_DIV_START;
         end
         S_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (stat.div_done) begin
               if (job_ff == JOB_CCT) begin
                  state_in = S_FINISH;
               end else begin
                  job_in   = job_type'(job_ff + 3'd1);
                  state_in = S_DIV_START;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_hold) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_last_job_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_WAIT && stat.div_done && job_ff == JOB_CCT)
      |=> state_ff == S_FINISH) else $error("last division did not finish item");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> state_ff == S_CPL_START)
      else $error("accepted beat did not start work");

endmodule
